// ===== rtl/lmcs_pkg.sv =====
// Shared types and constants of the LED matrix column scanner.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package lmcs_pkg;

    localparam int COLUMNS       = 8;
    localparam int ROWS          = 8;
    localparam int COLS_PER_SCAN = 1;

    localparam int STORE_DEPTH = COLUMNS * ROWS;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_IDX_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_IDX_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W       = (COLS_PER_SCAN > 1) ? $clog2(COLS_PER_SCAN) : 1;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    typedef enum logic [1:0] {
        K_WRITE,
        K_READ,
        K_SCAN,
        K_NOP
    } kind_t;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        kind_t                  kind;
        logic                   in_range;
        logic [IDX_W-1:0]       idx;
        logic [COL_IDX_W-1:0]   col_idx;
        logic [ROW_IDX_W-1:0]   row_idx;
        logic [7:0]             pixel;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/lmcs_front.sv =====
// Front end: takes input beats, decodes the operation and works out the
// store address and range check. Depends on lmcs_pkg.
`default_nettype none
module lmcs_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic [1:0]           operation,
    input  wire logic [2:0]           column,
    input  wire logic [2:0]           row,
    input  wire logic [7:0]           pixel_value,
    output logic                      push,
    output lmcs_pkg::cmd_t            push_cmd,
    input  wire logic                 fifo_full
);
    import lmcs_pkg::*;

    logic  hold_valid_reg;
    cmd_t  hold_cmd_reg;
    cmd_t  cmd_next;
    logic  take;

    always_comb
    begin
        cmd_next          = '0;
        cmd_next.in_range = ({1'b0, column} < 4'(COLUMNS)) && ({1'b0, row} < 4'(ROWS));
        cmd_next.col_idx  = COL_IDX_W'(column);
        cmd_next.row_idx  = ROW_IDX_W'(row);
        cmd_next.idx      = IDX_W'(int'(column) * ROWS + int'(row));
        cmd_next.pixel    = pixel_value;
        case (operation)
            OP_WRITE: cmd_next.kind = K_WRITE;
            OP_READ:  cmd_next.kind = K_READ;
            OP_SCAN:  cmd_next.kind = K_SCAN;
            default:  cmd_next.kind = K_NOP;
        endcase
    end

    assign push       = hold_valid_reg && !fifo_full;
    assign item_stall = hold_valid_reg && fifo_full;
    assign take       = item_valid && !item_stall;
    assign push_cmd   = hold_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lmcs_fifo.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on lmcs_pkg for the command type.
`default_nettype none
module lmcs_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lmcs_pkg::cmd_t   push_cmd,
    output logic                  full,
    input  wire logic             pop,
    output lmcs_pkg::cmd_t        pop_cmd,
    output logic                  empty
);
    import lmcs_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lmcs_back.sv =====
// Back end: pixel store, lit map, scan sequencer and result register.
// Depends on lmcs_pkg.
`default_nettype none
module lmcs_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    output logic                  pop,
    input  wire lmcs_pkg::cmd_t   pop_cmd,
    input  wire logic             empty,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic [7:0]            read_value,
    output logic [15:0]           drive_word
);
    import lmcs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                         state_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [COL_IDX_W-1:0]           scan_col_reg;
    logic [15:0]                    drive_acc_reg;
    logic [15:0]                    last_drive_reg;
    logic                           out_valid_reg;
    logic [7:0]                     read_value_reg;
    logic [15:0]                    drive_out_reg;
    logic                           rd_ok_reg;
    kind_t                          kind_reg;
    logic [STORE_DEPTH-1:0]         written_reg;
    logic [COLUMNS-1:0][ROWS-1:0]   lit_reg;

    logic [7:0]   mem [STORE_DEPTH];
    logic [7:0]   mem_rd_reg;

    logic         out_free;
    logic         out_load;
    logic         do_write;
    logic [15:0]  col_drive;
    logic [15:0]  drive_next;
    logic [7:0]   row_bits;

    assign pop      = (state_reg == S_IDLE) && !empty;
    assign do_write = pop && (pop_cmd.kind == K_WRITE) && pop_cmd.in_range;
    assign out_free = !out_valid_reg || !result_stall;
    assign out_load = (state_reg == S_DONE) && out_free;

    assign result_valid = out_valid_reg;
    assign read_value   = read_value_reg;
    assign drive_word   = drive_out_reg;

    // Contribution of the column under the scan pointer: its select bit and
    // the rows that hold a nonzero pixel.
    always_comb
    begin
        row_bits            = '0;
        row_bits[ROWS-1:0]  = lit_reg[scan_col_reg];
        col_drive           = '0;
        if (|lit_reg[scan_col_reg])
        begin
            col_drive = (16'h0100 << scan_col_reg) | {8'h00, row_bits};
        end
        drive_next = drive_acc_reg | col_drive;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_col_reg   <= '0;
            drive_acc_reg  <= '0;
            last_drive_reg <= '0;
            out_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            drive_out_reg  <= '0;
            rd_ok_reg      <= 1'b0;
            kind_reg       <= K_NOP;
            written_reg    <= '0;
            lit_reg        <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= out_load;
            end
            // The drive word is captured with the beat so that a later scan
            // cannot disturb a result that is still waiting.
            if (out_load)
            begin
                read_value_reg <= rd_ok_reg ? mem_rd_reg : 8'h00;
                drive_out_reg  <= last_drive_reg;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        kind_reg  <= pop_cmd.kind;
                        rd_ok_reg <= (pop_cmd.kind == K_READ) && pop_cmd.in_range
                                     && written_reg[pop_cmd.idx];
                        count_reg     <= '0;
                        drive_acc_reg <= '0;
                        if (do_write)
                        begin
                            written_reg[pop_cmd.idx] <= 1'b1;
                            lit_reg[pop_cmd.col_idx][pop_cmd.row_idx] <= |pop_cmd.pixel;
                        end
                        state_reg <= (pop_cmd.kind == K_SCAN) ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN:
                begin
                    drive_acc_reg <= drive_next;
                    scan_col_reg  <= (scan_col_reg == COL_IDX_W'(COLUMNS - 1))
                                     ? '0 : scan_col_reg + 1'b1;
                    count_reg     <= count_reg + 1'b1;
                    if (count_reg == CNT_W'(COLS_PER_SCAN - 1))
                    begin
                        last_drive_reg <= drive_next;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Pixel store; entries never written read back as zero via written_reg.
    // The read data is held from the pop until the result is loaded.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[pop_cmd.idx] <= pop_cmd.pixel;
        end
        if (pop)
        begin
            mem_rd_reg <= mem[pop_cmd.idx];
        end
    end

    a_scan_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(scan_col_reg) < COLUMNS)
        else $error("scan column pointer out of range");

    a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && (count_reg == CNT_W'(COLS_PER_SCAN - 1))
        |=> (state_reg == S_DONE))
        else $error("scan did not finish after its column count");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != S_IDLE))
        else $error("command taken without leaving idle");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (kind_reg != K_READ) |=> (read_value_reg == 8'h00))
        else $error("non-read result carries a nonzero read value");

endmodule
`default_nettype wire

// ===== rtl/led_matrix_column_scanner.sv =====
// LED matrix column scanner: front end, command queue and back end.
// Beats pass the front-end hold register, the command queue, the back-end
// sequencer and the result register; new beats are taken while the back end
// is busy until the queue fills. The sequencer visits one column per cycle.
// Reset (rst_n, asynchronous, active low) clears the written flags (so the store
// reads zero), scan column and drive word at once; there is no clearing pass.
`default_nettype none
module led_matrix_column_scanner (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    output logic              item_stall,
    input  wire logic [1:0]   operation,
    input  wire logic [2:0]   column,
    input  wire logic [2:0]   row,
    input  wire logic [7:0]   pixel_value,
    output logic              result_valid,
    input  wire logic         result_stall,
    output logic [7:0]        read_value,
    output logic [15:0]       drive_word
);
    import lmcs_pkg::*;

    logic  push;
    cmd_t  push_cmd;
    logic  fifo_full;
    logic  pop;
    cmd_t  pop_cmd;
    logic  fifo_empty;

    lmcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .operation   (operation),
        .column      (column),
        .row         (row),
        .pixel_value (pixel_value),
        .push        (push),
        .push_cmd    (push_cmd),
        .fifo_full   (fifo_full)
    );

    lmcs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    lmcs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .pop_cmd      (pop_cmd),
        .empty        (fifo_empty),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .read_value   (read_value),
        .drive_word   (drive_word)
    );

endmodule
`default_nettype wire
